// ----- hdl/lbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lbp_pkg: shared types and constants
// Payload widths, window column type, result record and register indexes
// of the 3x3 local binary pattern unit.
// ----------------------------------------------------------------------------
package lbp_pkg;

	localparam int PIX_W     = 8;
	localparam int CODE_W    = 8;
	localparam int CCOL_W    = 11;
	localparam int CROW_W    = 12;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 13;
	localparam int RWID_W    = 12;
	localparam int RCNT_W    = 13;

	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = $clog2(RES_DEPTH);
	localparam int RES_CW    = $clog2(RES_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_WIDTH = 1'b0,
		CFG_ROW_COUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} col_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [CCOL_W-1:0] ccol;
		logic [CROW_W-1:0] crow;
		logic              last;
	} res_t;

endpackage

// ----- hdl/lbp_ifs.sv -----
// ----------------------------------------------------------------------------
// lbp_ifs: channel interfaces
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface lbp_pix_if import lbp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface lbp_res_if import lbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] pattern_code;
	logic [CCOL_W-1:0] centre_column;
	logic [CROW_W-1:0] centre_row;
	logic              frame_last;

	modport source (output valid, output pattern_code, output centre_column,
		output centre_row, output frame_last, input ready);
	modport sink (input valid, input pattern_code, input centre_column,
		input centre_row, input frame_last, output ready);
endinterface

interface lbp_cfg_if import lbp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/lbp_line_buf.sv -----
// ----------------------------------------------------------------------------
// lbp_line_buf: two-row line store
// One word per column holds the pixels of the two previous rows. After reset
// a sweep writes zeros to every column before ready rises.
// ----------------------------------------------------------------------------
module lbp_line_buf import lbp_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [2*PIX_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [2*PIX_W-1:0] wr_data,
	output logic               ready
);

	logic [2*PIX_W-1:0] mem_q [DEPTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [AW-1:0]      clr_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign ready   = !busy_q;

endmodule

// ----- hdl/lbp_col_cell.sv -----
// ----------------------------------------------------------------------------
// lbp_col_cell: one window column
// Holds three vertically stacked pixels and takes its neighbor's column on
// each shift.
// ----------------------------------------------------------------------------
module lbp_col_cell import lbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  col_t col_in,
	output col_t col
);

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col = col_q;

endmodule

// ----- hdl/local_binary_pattern_3x3_unit.sv -----
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3_unit: streaming LBP(8,1) code generator
//
// Pixels enter in raster order on the pixels channel, one beat per pixel. A
// frame starts after reset and after the last pixel of the previous frame.
// For every interior pixel one beat leaves on the results channel with the
// 8-bit pattern code, the centre position and a flag on the last centre of
// the frame. Border pixels give no beat.
// Registers are written on the cfg channel (index 0 row width, index 1 row
// count); the user must write them only while the unit is idle; it does not
// enforce this. Stored values outside 3..MAX are clamped. Throughput is one
// pixel per cycle unless stalled. A result takes three steps: line store read,
// window column shift, compare into the result queue. After reset pixels.ready
// stays low while the line store is cleared. A four-entry result queue with
// credit control lets pixels flow while a result waits; when the receiver
// stalls the queue fills and pixels.ready drops until beats are taken.
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3_unit import lbp_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	lbp_pix_if.sink   pixels,
	lbp_res_if.source results,
	lbp_cfg_if.sink   cfg
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WL = $clog2(MAX_WIDTH + 1);
	localparam int HL = $clog2(MAX_HEIGHT + 1);

	logic [RWID_W-1:0] row_width_q;
	logic [RCNT_W-1:0] row_count_q;
	logic [WL-1:0]     w_lim;
	logic [HL-1:0]     h_lim;
	logic [CW-1:0]     c_q;
	logic [RW-1:0]     r_q;

	logic accept;
	logic produce;
	logic last;
	logic row_end;
	logic frame_end;

	logic              v_s1;
	logic              res_s1;
	logic [PIX_W-1:0]  px_s1;
	logic [CW-1:0]     c_s1;
	logic [CCOL_W-1:0] ccol_s1;
	logic [CROW_W-1:0] crow_s1;
	logic              last_s1;

	logic              v_s2;
	logic [CCOL_W-1:0] ccol_s2;
	logic [CROW_W-1:0] crow_s2;
	logic              last_s2;

	logic [2*PIX_W-1:0] lb_rd;
	logic               lb_ready;
	col_t               new_col;
	col_t               cols [3];
	logic [CODE_W-1:0]  code;

	res_t              fifo_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_ptr_q;
	logic [RES_AW-1:0] rd_ptr_q;
	logic [RES_CW-1:0] cnt_q;
	logic              push;
	logic              pop;
	res_t              head;

	// Register port.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= RWID_W'(640);
			row_count_q <= RCNT_W'(480);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_ROW_WIDTH: row_width_q <= cfg.data[RWID_W-1:0];
				CFG_ROW_COUNT: row_count_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(row_width_q) < 32'd3) begin
			w_lim = WL'(3);
		end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
			w_lim = WL'(MAX_WIDTH);
		end else begin
			w_lim = WL'(row_width_q);
		end
		if (32'(row_count_q) < 32'd3) begin
			h_lim = HL'(3);
		end else if (32'(row_count_q) > 32'(MAX_HEIGHT)) begin
			h_lim = HL'(MAX_HEIGHT);
		end else begin
			h_lim = HL'(row_count_q);
		end
	end

	// Frame position and result selection.
	assign accept    = pixels.valid && pixels.ready;
	assign produce   = (32'(r_q) >= 32'd2) && (32'(c_q) >= 32'd2)
		&& (32'(r_q) < 32'(h_lim)) && (32'(c_q) < 32'(w_lim));
	assign last      = (32'(r_q) + 32'd1 == 32'(h_lim))
		&& (32'(c_q) + 32'd1 == 32'(w_lim));
	assign row_end   = (32'(c_q) + 32'd1 >= 32'(w_lim));
	assign frame_end = (32'(r_q) + 32'd1 >= 32'(h_lim));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				c_q <= '0;
				r_q <= frame_end ? '0 : r_q + 1'b1;
			end else begin
				c_q <= c_q + 1'b1;
			end
		end
	end

	// Stage 1: line store data arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			res_s1 <= 1'b0;
		end else begin
			v_s1   <= accept;
			res_s1 <= accept && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixels.pixel;
			c_s1    <= c_q;
			ccol_s1 <= CCOL_W'(32'(c_q) - 32'd1);
			crow_s1 <= CROW_W'(32'(r_q) - 32'd1);
			last_s1 <= last;
		end
	end

	lbp_line_buf #(
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (c_q),
		.rd_data (lb_rd),
		.wr_en   (v_s1),
		.wr_addr (c_s1),
		.wr_data ({lb_rd[PIX_W-1:0], px_s1}),
		.ready   (lb_ready)
	);

	// Window: three column cells shifting right to left.
	assign new_col = '{top: lb_rd[2*PIX_W-1:PIX_W], mid: lb_rd[PIX_W-1:0], bot: px_s1};

	lbp_col_cell u_col2 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (v_s1),
		.col_in (new_col),
		.col    (cols[2])
	);

	for (genvar i = 0; i < 2; i++) begin : g_cells
		lbp_col_cell u_col (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (v_s1),
			.col_in (cols[i+1]),
			.col    (cols[i])
		);
	end

	// Stage 2: compare against the centre.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s1) begin
			ccol_s2 <= ccol_s1;
			crow_s2 <= crow_s1;
			last_s2 <= last_s1;
		end
	end

	assign code[0] = cols[2].mid > cols[1].mid;
	assign code[1] = cols[2].bot > cols[1].mid;
	assign code[2] = cols[1].bot > cols[1].mid;
	assign code[3] = cols[0].bot > cols[1].mid;
	assign code[4] = cols[0].mid > cols[1].mid;
	assign code[5] = cols[0].top > cols[1].mid;
	assign code[6] = cols[1].top > cols[1].mid;
	assign code[7] = cols[2].top > cols[1].mid;

	// Result queue with credit toward the pixel side.
	assign push = v_s2;
	assign pop  = results.valid && results.ready;
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{code: code, ccol: ccol_s2, crow: crow_s2, last: last_s2};
		end
	end

	assign pixels.ready = lb_ready
		&& (32'(cnt_q) + 32'(v_s1) + 32'(v_s2) < 32'(RES_DEPTH));

	assign results.valid         = (cnt_q != '0);
	assign results.pattern_code  = head.code;
	assign results.centre_column = head.ccol;
	assign results.centre_row    = head.crow;
	assign results.frame_last    = head.last;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(RES_DEPTH))
		else $error("result queue count beyond its depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (32'(cnt_q) < 32'(RES_DEPTH)) || pop)
		else $error("result pushed into a full queue");

	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		!lb_ready |-> !pixels.ready)
		else $error("pixel taken during line store clear");

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && v_s1) |-> (c_q != c_s1))
		else $error("line store read and write hit the same column");

	a_res_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("result stage valid without a preceding pixel");
`endif

endmodule

// ----- tb/lbp_code_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_code_checker: pattern code predictor and result comparator
// Watches the pixel, result and register channels of the LBP unit. It keeps
// its own line stores, 3x3 window, frame position and register copies, works
// out the code for every accepted pixel that has an interior centre, and
// compares each result beat with the oldest pending code field by field.
// ----------------------------------------------------------------------------
module lbp_code_checker import lbp_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic clk,
	input  logic arst_n,
	lbp_pix_if   pixels,
	lbp_res_if   results,
	lbp_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);

	logic [RWID_W-1:0] width_reg;
	logic [RCNT_W-1:0] height_reg;
	logic [PIX_W-1:0]  line_two_up [MAX_WIDTH];
	logic [PIX_W-1:0]  line_one_up [MAX_WIDTH];
	col_t              win [3];
	int unsigned       col_pos;
	int unsigned       row_pos;
	res_t              pending_codes [$];
	res_t              head;

	function automatic int unsigned limit_range(input int unsigned v, input int unsigned lo,
		input int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic note_mismatch(input string what);
		$display("%0t ns lbp check: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic predict_pattern(input logic [PIX_W-1:0] px);
		int unsigned      w;
		int unsigned      h;
		int unsigned      c;
		int unsigned      r;
		col_t             fresh;
		res_t             code_rec;
		logic [PIX_W-1:0] ctr;
		w = limit_range(width_reg, 3, MAX_WIDTH);
		h = limit_range(height_reg, 3, MAX_HEIGHT);
		c = col_pos;
		r = row_pos;
		fresh.top = line_two_up[c];
		fresh.mid = line_one_up[c];
		fresh.bot = px;
		line_two_up[c] = fresh.mid;
		line_one_up[c] = px;
		win[0] = win[1];
		win[1] = win[2];
		win[2] = fresh;
		if (r >= 2 && c >= 2 && r < h && c < w) begin
			ctr = win[1].mid;
			code_rec.code = {win[2].top > ctr, win[1].top > ctr, win[0].top > ctr,
				win[0].mid > ctr, win[0].bot > ctr, win[1].bot > ctr,
				win[2].bot > ctr, win[2].mid > ctr};
			code_rec.ccol = CCOL_W'(c - 1);
			code_rec.crow = CROW_W'(r - 1);
			code_rec.last = (r == h - 1) && (c == w - 1);
			pending_codes.push_back(code_rec);
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = RWID_W'(640);
			height_reg = RCNT_W'(480);
			foreach (line_two_up[i]) begin
				line_two_up[i] = '0;
				line_one_up[i] = '0;
			end
			win = '{default: '0};
			col_pos = 0;
			row_pos = 0;
			pending_codes.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_ROW_WIDTH) begin
					width_reg = cfg.data[RWID_W-1:0];
				end else begin
					height_reg = cfg.data[RCNT_W-1:0];
				end
			end
			if (pixels.valid && pixels.ready) begin
				predict_pattern(pixels.pixel);
			end
			if (results.valid && results.ready) begin
				if (pending_codes.size() == 0) begin
					note_mismatch($sformatf("result beat with no pending code, row %0d col %0d",
						results.centre_row, results.centre_column));
				end else begin
					head = pending_codes.pop_front();
					if (results.pattern_code !== head.code)
						note_mismatch($sformatf("pattern_code %h, want %h at row %0d col %0d",
							results.pattern_code, head.code, head.crow, head.ccol));
					if (results.centre_column !== head.ccol)
						note_mismatch($sformatf("centre_column %0d, want %0d",
							results.centre_column, head.ccol));
					if (results.centre_row !== head.crow)
						note_mismatch($sformatf("centre_row %0d, want %0d",
							results.centre_row, head.crow));
					if (results.frame_last !== head.last)
						note_mismatch($sformatf("frame_last %b, want %b at row %0d col %0d",
							results.frame_last, head.last, head.crow, head.ccol));
				end
			end
			outstanding <= pending_codes.size();
		end
	end

endmodule

// ----- tb/local_binary_pattern_3x3_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3_unit_tb: stimulus and verdict for the LBP unit
// Runs a few tiny hand-made frames, one wide frame, one tall frame and a
// stretch of random bursts under random register settings, with random
// idling on both channels and one long result stall. A checker beside the
// unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3_unit_tb;
	import lbp_pkg::*;

	localparam int MAX_WIDTH     = 2048;
	localparam int MAX_HEIGHT    = 4096;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_AT       = 100;
	localparam int HOLD_CYCLES   = 400;
	localparam int WIDE_COLS     = 250;
	localparam int TALL_ROWS     = 100;
	localparam int RANDOM_PIXELS = 450;
	localparam int QUIET_FROM    = 260;
	localparam int QUIET_TO      = 340;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   beats_taken = 0;
	bit   sender_idles = 1'b1;

	logic [PIX_W-1:0] frame_a [9] = '{8'd50, 8'd101, 8'd200, 8'd100, 8'd100, 8'd99,
		8'd0, 8'd255, 8'd101};
	logic [PIX_W-1:0] frame_c_head [11] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
		8'd255, 8'd128, 8'd255, 8'd0, 8'd0};
	logic [PIX_W-1:0] frame_c_tail [4] = '{8'd17, 8'd0, 8'd255, 8'd254};

	lbp_pix_if pixels ();
	lbp_res_if results ();
	lbp_cfg_if cfg ();

	local_binary_pattern_3x3_unit #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pixels),
		.results(results),
		.cfg(cfg)
	);

	lbp_code_checker #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) code_check (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pixels),
		.results(results),
		.cfg(cfg),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("local_binary_pattern_3x3_unit verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (results.valid && results.ready) beats_taken <= beats_taken + 1;
	end

	initial begin : result_sink
		bit held_off;
		held_off = 1'b0;
		forever begin
			if (!held_off && beats_taken >= HOLD_AT) begin
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held_off = 1'b1;
			end else begin
				results.ready <= (beats_taken >= QUIET_FROM && beats_taken < QUIET_TO) ||
					($urandom_range(0, 99) >= 6);
				@(posedge clk);
			end
		end
	end

	function automatic logic [PIX_W-1:0] pick_pixel(input bit narrow);
		logic [PIX_W-1:0] tie_values [4];
		tie_values = '{8'd0, 8'd127, 8'd128, 8'd255};
		if (narrow) return tie_values[$urandom_range(0, 3)];
		return PIX_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [CFG_DAT_W-1:0] pick_width();
		int sel;
		int w;
		sel = $urandom_range(0, 99);
		if (sel < 75) w = $urandom_range(3, 12);
		else if (sel < 92) w = $urandom_range(0, 2);
		else w = $urandom_range(MAX_WIDTH + 1, 4095);
		return {1'($urandom_range(0, 1)), RWID_W'(w)};
	endfunction

	function automatic logic [CFG_DAT_W-1:0] pick_height();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 75) return CFG_DAT_W'($urandom_range(3, 8));
		if (sel < 90) return CFG_DAT_W'($urandom_range(0, 2));
		return CFG_DAT_W'($urandom_range(MAX_HEIGHT + 1, 8191));
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] value);
		if (sender_idles && $urandom_range(0, 99) < 6) begin
			pixels.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.pixel <= value;
		@(posedge clk);
		while (!pixels.ready) @(posedge clk);
	endtask

	task automatic settle();
		pixels.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int choice;
		int burst;
		int random_pixels;
		bit narrow;
		random_pixels = 0;
		arst_n <= 1'b0;
		pixels.valid <= 1'b0;
		pixels.pixel <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_ROW_WIDTH;
		cfg.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_ROW_WIDTH, 13'd3);
		write_reg(CFG_ROW_COUNT, 13'd2);
		foreach (frame_a[i]) send_pixel(frame_a[i]);
		settle();
		write_reg(CFG_ROW_WIDTH, 13'd4);
		write_reg(CFG_ROW_COUNT, 13'd4);
		foreach (frame_c_head[i]) send_pixel(frame_c_head[i]);
		settle();
		write_reg(CFG_ROW_WIDTH, 13'd1);
		foreach (frame_c_tail[i]) send_pixel(frame_c_tail[i]);
		settle();

		write_reg(CFG_ROW_WIDTH, CFG_DAT_W'(WIDE_COLS));
		write_reg(CFG_ROW_COUNT, 13'd3);
		sender_idles = 1'b0;
		repeat (3 * WIDE_COLS) send_pixel(pick_pixel($urandom_range(0, 1)));
		sender_idles = 1'b1;
		settle();
		write_reg(CFG_ROW_WIDTH, 13'd3);
		write_reg(CFG_ROW_COUNT, CFG_DAT_W'(TALL_ROWS));
		repeat (3 * TALL_ROWS) send_pixel(pick_pixel($urandom_range(0, 1)));
		settle();

		while (random_pixels < RANDOM_PIXELS) begin
			choice = $urandom_range(0, 3);
			if (choice != 0) settle();
			if (choice[0]) write_reg(CFG_ROW_WIDTH, pick_width());
			if (choice[1]) write_reg(CFG_ROW_COUNT, pick_height());
			burst = $urandom_range(10, 120);
			narrow = $urandom_range(0, 1);
			repeat (burst) send_pixel(pick_pixel(narrow));
			random_pixels += burst;
		end
		settle();

		if (mismatches == 0) begin
			$display("local_binary_pattern_3x3_unit verification clean");
		end else begin
			$display("local_binary_pattern_3x3_unit verification failed");
		end
		$finish;
	end

endmodule
